// ===== rtl/core/rdc_pkg.sv =====
// Shared constants and controller/datapath interface types for the radix converter.
package rdc_pkg;

    localparam int VALUE_BITS_DEF  = 31;
    localparam int DIGIT_DEPTH_DEF = 32;
    localparam int DIGIT_W         = 6;
    localparam int BASE_W          = 6;
    // quotient bits resolved per divider cycle
    localparam int DIV_BITS        = 4;

    localparam logic [BASE_W-1:0] BASE_MIN = 6'd2;
    localparam logic [BASE_W-1:0] BASE_MAX = 6'd36;

    typedef struct packed {
        logic load;
        logic div_step;
        logic push;
        logic pop_rd;
        logic out_load;
        logic out_zero;
    } cmd_t;

    typedef struct packed {
        logic step_last;
        logic quot_zero;
        logic cnt_zero;
        logic out_free;
        logic value_zero;
    } status_t;

endpackage

// ===== rtl/core/rdc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module rdc_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/rdc_datapath.sv =====
// Datapath: multi-bit restoring divider, digit stack and output register.
module rdc_datapath #(
    parameter int VALUE_BITS  = rdc_pkg::VALUE_BITS_DEF,
    parameter int DIGIT_DEPTH = rdc_pkg::DIGIT_DEPTH_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [VALUE_BITS-1:0]      s_value,
    input  logic [rdc_pkg::BASE_W-1:0] s_base,
    input  rdc_pkg::cmd_t              cmd,
    output rdc_pkg::status_t           status,
    input  logic                       m_ready,
    output logic                       m_valid,
    output logic [rdc_pkg::DIGIT_W-1:0] m_digit,
    output logic                       m_last,
    output logic                       m_empty_res
);
    import rdc_pkg::*;

    localparam int STEPS = (VALUE_BITS + DIV_BITS - 1) / DIV_BITS;
    localparam int PW    = STEPS * DIV_BITS;
    localparam int SW    = $clog2(STEPS);
    localparam int CW    = $clog2(DIGIT_DEPTH + 1);
    localparam int AW    = $clog2(DIGIT_DEPTH);

    // div_reg holds the dividend; quotient bits shift in from the bottom
    logic [PW-1:0]      div_reg, div_next;
    logic [BASE_W-1:0]  rem_reg, rem_next;
    logic [BASE_W-1:0]  base_reg;
    logic [SW-1:0]      step_reg;
    logic [CW-1:0]      count_reg, count_next;
    logic               out_valid_reg;
    logic [DIGIT_W-1:0] out_digit_reg;
    logic               out_last_reg;
    logic               out_empty_reg;

    logic [BASE_W-1:0]  base_sat;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [AW-1:0]      ram_raddr;
    logic [DIGIT_W-1:0] ram_rdata;
    logic               stack_full;

    always_comb begin
        if (s_base < BASE_MIN) begin
            base_sat = BASE_MIN;
        end else if (s_base > BASE_MAX) begin
            base_sat = BASE_MAX;
        end else begin
            base_sat = s_base;
        end
    end

    // DIV_BITS chained compare/subtract steps on a 7-bit partial remainder
    always_comb begin
        logic [PW-1:0]     d;
        logic [BASE_W-1:0] r;
        logic [BASE_W:0]   t;
        d = div_reg;
        r = rem_reg;
        for (int i = 0; i < DIV_BITS; i++) begin
            t = {r, d[PW-1]};
            d = {d[PW-2:0], 1'b0};
            if (t >= {1'b0, base_reg}) begin
                t    = t - {1'b0, base_reg};
                d[0] = 1'b1;
            end
            r = t[BASE_W-1:0];
        end
        div_next = d;
        rem_next = r;
    end

    assign stack_full = (count_reg >= CW'(DIGIT_DEPTH));
    assign ram_we     = cmd.push && !stack_full;
    assign ram_waddr  = count_reg[AW-1:0];
    assign ram_raddr  = AW'(count_reg - CW'(1));

    always_comb begin
        count_next = count_reg;
        if (cmd.load) begin
            count_next = '0;
        end else if (ram_we) begin
            count_next = count_reg + CW'(1);
        end else if (cmd.pop_rd) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg   <= '0;
            base_reg  <= BASE_MIN;
            step_reg  <= '0;
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
            if (cmd.load) begin
                rem_reg  <= '0;
                base_reg <= base_sat;
                step_reg <= '0;
            end else if (cmd.div_step) begin
                rem_reg  <= rem_next;
                step_reg <= (step_reg == SW'(STEPS - 1)) ? '0 : step_reg + SW'(1);
            end else if (cmd.push) begin
                rem_reg <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            div_reg <= PW'(s_value);
        end else if (cmd.div_step) begin
            div_reg <= div_next;
        end
    end

    rdc_ram #(
        .WIDTH (DIGIT_W),
        .DEPTH (DIGIT_DEPTH)
    ) u_stack (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (rem_reg),
        .re    (cmd.pop_rd),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load || cmd.out_zero) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_zero) begin
            out_digit_reg <= '0;
            out_last_reg  <= 1'b1;
            out_empty_reg <= 1'b1;
        end else if (cmd.out_load) begin
            out_digit_reg <= ram_rdata;
            out_last_reg  <= (count_reg == '0);
            out_empty_reg <= 1'b0;
        end
    end

    assign status.step_last  = (step_reg == SW'(STEPS - 1));
    assign status.quot_zero  = (div_reg == '0);
    assign status.cnt_zero   = (count_reg == '0);
    assign status.out_free   = !out_valid_reg || m_ready;
    assign status.value_zero = (s_value == '0);

    assign m_valid     = out_valid_reg;
    assign m_digit     = out_digit_reg;
    assign m_last      = out_last_reg;
    assign m_empty_res = out_empty_reg;

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.out_load || cmd.out_zero) |-> (!out_valid_reg || m_ready))
        else $error("output register overwritten while holding a transaction");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DIGIT_DEPTH))
        else $error("digit count beyond stack depth");

    a_rem_below_base: assert property (@(posedge aclk) disable iff (!aresetn)
        rem_reg < base_reg)
        else $error("partial remainder not below base");

endmodule

// ===== rtl/core/rdc_ctrl.sv =====
// Controller: sequences load, divide, push, pop and output of one conversion.
module rdc_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  rdc_pkg::status_t  status,
    output rdc_pkg::cmd_t     cmd
);
    import rdc_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_ZERO   = 3'd1;
    localparam logic [2:0] ST_DIV    = 3'd2;
    localparam logic [2:0] ST_PUSH   = 3'd3;
    localparam logic [2:0] ST_POP_RD = 3'd4;
    localparam logic [2:0] ST_POP_LD = 3'd5;

    logic [2:0] state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = status.value_zero ? ST_ZERO : ST_DIV;
                end
            end
            ST_ZERO: begin
                if (status.out_free) begin
                    cmd.out_zero = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (status.step_last) begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH: begin
                cmd.push   = 1'b1;
                state_next = status.quot_zero ? ST_POP_RD : ST_DIV;
            end
            ST_POP_RD: begin
                cmd.pop_rd = 1'b1;
                state_next = ST_POP_LD;
            end
            ST_POP_LD: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = status.cnt_zero ? ST_IDLE : ST_POP_RD;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.pop_rd |-> !status.cnt_zero)
        else $error("pop from empty digit stack");

    a_last_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.out_load && status.cnt_zero) |=> (state_reg == ST_IDLE))
        else $error("controller not idle after final digit");

endmodule

// ===== rtl/core/radix_digit_converter.sv =====
// Each digit costs a full division of the quotient followed by a push, then digits
// leave with a pop read and an output load each; a zero value skips the divider.
// One conversion at a time; when the sink is ready, the 4-bit-per-cycle divider
// sets most of the time per digit. The next value is taken once the final digit
// sits in the output register. Reset clears control and the output valid; the
// digit RAM is not cleared, every entry is written before it is read.
module radix_digit_converter #(
    parameter int VALUE_BITS  = rdc_pkg::VALUE_BITS_DEF,
    parameter int DIGIT_DEPTH = rdc_pkg::DIGIT_DEPTH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [VALUE_BITS-1:0]       s_value,
    input  logic [rdc_pkg::BASE_W-1:0]  s_base,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [rdc_pkg::DIGIT_W-1:0] m_digit,
    output logic                        m_last,
    output logic                        m_empty_res
);
    import rdc_pkg::*;

    cmd_t    cmd;
    status_t status;

    rdc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    rdc_datapath #(
        .VALUE_BITS  (VALUE_BITS),
        .DIGIT_DEPTH (DIGIT_DEPTH)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_value     (s_value),
        .s_base      (s_base),
        .cmd         (cmd),
        .status      (status),
        .m_ready     (m_ready),
        .m_valid     (m_valid),
        .m_digit     (m_digit),
        .m_last      (m_last),
        .m_empty_res (m_empty_res)
    );

endmodule

// ===== tb/radix_digit_converter_test.sv =====
// Self-checking testbench for radix_digit_converter: random and directed conversions.
`timescale 1ns / 1ps

module radix_digit_converter_test;

    localparam int VB          = rdc_pkg::VALUE_BITS_DEF;
    localparam int DEPTH       = rdc_pkg::DIGIT_DEPTH_DEF;
    localparam int STALL_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        logic [VB-1:0]              value;
        logic [rdc_pkg::BASE_W-1:0] base;
        logic                       hold;   // wait for all digits before presenting
    } conv_req_t;

    typedef struct packed {
        logic [rdc_pkg::DIGIT_W-1:0] digit;
        logic                        last;
        logic                        empty_res;
    } digit_rec_t;

    logic                        aclk        = 1'b0;
    logic                        aresetn     = 1'b0;
    logic                        s_valid     = 1'b0;
    logic                        s_ready;
    logic [VB-1:0]               s_value     = '0;
    logic [rdc_pkg::BASE_W-1:0]  s_base      = '0;
    logic                        m_valid;
    logic                        m_ready     = 1'b0;
    logic [rdc_pkg::DIGIT_W-1:0] m_digit;
    logic                        m_last;
    logic                        m_empty_res;

    conv_req_t  pending_reqs[$];
    digit_rec_t digits_due[$];
    logic [rdc_pkg::DIGIT_W-1:0] digit_stack[DEPTH];

    int unsigned src_idle_pct = 18;
    int unsigned snk_idle_pct = 68;
    int unsigned mismatch_count = 0;
    int unsigned stall_cycles = 0;

    radix_digit_converter u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_value     (s_value),
        .s_base      (s_base),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_digit     (m_digit),
        .m_last      (m_last),
        .m_empty_res (m_empty_res)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Repeated division; remainders stacked, then popped most significant first.
    task automatic convert_to_digits(input logic [VB-1:0] value,
                                     input logic [rdc_pkg::BASE_W-1:0] base_in);
        logic [rdc_pkg::BASE_W-1:0] radix;
        logic [VB-1:0]              quot;
        int unsigned                depth;
        digit_rec_t                 rec;
        radix = base_in;
        if (radix < rdc_pkg::BASE_MIN) radix = rdc_pkg::BASE_MIN;
        if (radix > rdc_pkg::BASE_MAX) radix = rdc_pkg::BASE_MAX;
        quot  = value;
        depth = 0;
        if (quot == '0) begin
            rec.digit     = '0;
            rec.last      = 1'b1;
            rec.empty_res = 1'b1;
            digits_due.push_back(rec);
        end else begin
            while (quot != '0) begin
                if (depth < DEPTH) begin
                    digit_stack[depth] = rdc_pkg::DIGIT_W'(quot % radix);
                    depth++;
                end
                quot = quot / radix;
            end
            while (depth > 0) begin
                depth--;
                rec.digit     = digit_stack[depth];
                rec.last      = (depth == 0);
                rec.empty_res = 1'b0;
                digits_due.push_back(rec);
            end
        end
    endtask

    // Driver
    always @(posedge aclk) begin
        conv_req_t req;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                convert_to_digits(s_value, s_base);
            end
            if (!s_valid || s_ready) begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= src_idle_pct
                        && !(pending_reqs[0].hold && digits_due.size() != 0)) begin
                    req = pending_reqs.pop_front();
                    s_valid <= 1'b1;
                    s_value <= req.value;
                    s_base  <= req.base;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor
    always @(posedge aclk) begin
        digit_rec_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (digits_due.size() == 0) begin
                    $display("%0t: unexpected transaction digit=%0d last=%0b empty=%0b",
                             $time, m_digit, m_last, m_empty_res);
                    mismatch_count++;
                end else begin
                    want = digits_due.pop_front();
                    if (m_digit !== want.digit) begin
                        $display("%0t: digit mismatch expected %0d actual %0d",
                                 $time, want.digit, m_digit);
                        mismatch_count++;
                    end
                    if (m_last !== want.last) begin
                        $display("%0t: last mismatch expected %0b actual %0b",
                                 $time, want.last, m_last);
                        mismatch_count++;
                    end
                    if (m_empty_res !== want.empty_res) begin
                        $display("%0t: empty_res mismatch expected %0b actual %0b",
                                 $time, want.empty_res, m_empty_res);
                        mismatch_count++;
                    end
                end
            end
            m_ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // Watchdog: no transaction on either channel for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: timeout, %0d digits outstanding", $time, digits_due.size());
            $display("*** FAILED ***");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic add_req(input logic [VB-1:0] value,
                           input logic [rdc_pkg::BASE_W-1:0] base,
                           input logic hold);
        conv_req_t req;
        req.value = value;
        req.base  = base;
        req.hold  = hold;
        pending_reqs.push_back(req);
    endtask

    task automatic add_random_reqs(input int unsigned count);
        logic [VB-1:0]              value;
        logic [rdc_pkg::BASE_W-1:0] base;
        for (int unsigned i = 0; i < count; i++) begin
            value = VB'($urandom());
            value = value >> $urandom_range(0, VB - 1);
            if ($urandom_range(99) < 8) value = '0;
            if ($urandom_range(99) < 85)
                base = rdc_pkg::BASE_W'($urandom_range(2, 36));
            else
                base = rdc_pkg::BASE_W'($urandom_range(0, 63));
            add_req(value, base, (i == 0) || ($urandom_range(99) < 5));
        end
    endtask

    task automatic wait_idle();
        while (pending_reqs.size() != 0 || s_valid || digits_due.size() != 0)
            @(posedge aclk);
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: zero value, extreme values, saturated bases, hex digits
        add_req('0, 6'd10, 1'b1);
        add_req('0, 6'd0, 1'b0);
        add_req('0, 6'd63, 1'b0);
        add_req({VB{1'b1}}, 6'd2, 1'b0);
        add_req({VB{1'b1}}, 6'd36, 1'b0);
        add_req({VB{1'b1}}, 6'd0, 1'b0);
        add_req({VB{1'b1}}, 6'd1, 1'b0);
        add_req({VB{1'b1}}, 6'd37, 1'b0);
        add_req({VB{1'b1}}, 6'd63, 1'b0);
        add_req(VB'(1), 6'd2, 1'b0);
        add_req(VB'(1), 6'd36, 1'b0);
        add_req(VB'(35), 6'd36, 1'b0);
        add_req(VB'(36), 6'd36, 1'b0);
        add_req(VB'(9), 6'd10, 1'b0);
        add_req(VB'(10), 6'd10, 1'b0);
        add_req(VB'(32'h0FEDCBA9), 6'd16, 1'b0);
        add_req(VB'(32'h40000000), 6'd2, 1'b0);
        add_req(VB'(32'h55555555), 6'd7, 1'b0);
        add_req(VB'(32'h2AAAAAAA), 6'd3, 1'b1);
        add_req(VB'(1295), 6'd36, 1'b0);
        add_req(VB'(255), 6'd42, 1'b0);
        add_req(VB'(32'h7FFFFFFE), 6'd35, 1'b0);
        add_random_reqs(25);
        wait_idle();

        src_idle_pct = 68;
        snk_idle_pct = 18;
        add_random_reqs(45);
        wait_idle();

        src_idle_pct = 0;
        snk_idle_pct = 0;
        add_random_reqs(40);
        wait_idle();

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
